>>> rtl/utf8d_pkg.sv
// Shared types, codes and helpers for the UTF-8 stream decoder.
package utf8d_pkg;

  // Input transaction: one raw byte and its end-of-string mark.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } in_item_t;

  // Result transaction: code point, bytes consumed and status.
  typedef struct packed {
    logic [20:0] code_point;
    logic [2:0]  sequence_length;
    logic [2:0]  status;
  } out_item_t;

  // Status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_LEAD  = 3'd1;
  localparam logic [2:0] ST_TRUNC     = 3'd2;
  localparam logic [2:0] ST_BAD_CONT  = 3'd3;
  localparam logic [2:0] ST_OVERLONG  = 3'd4;
  localparam logic [2:0] ST_RANGE     = 3'd5;
  localparam logic [2:0] ST_SURROGATE = 3'd6;

  // Code point limits.
  localparam logic [20:0] CP_MAX     = 21'h10FFFF;
  localparam logic [20:0] CP_SURR_LO = 21'h00D800;
  localparam logic [20:0] CP_SURR_HI = 21'h00DFFF;
  localparam logic [20:0] CP_MIN_2   = 21'h000080;
  localparam logic [20:0] CP_MIN_3   = 21'h000800;
  localparam logic [20:0] CP_MIN_4   = 21'h010000;

  // Sequence lengths.
  localparam logic [2:0] LEN_1 = 3'd1;
  localparam logic [2:0] LEN_2 = 3'd2;
  localparam logic [2:0] LEN_3 = 3'd3;
  localparam logic [2:0] LEN_4 = 3'd4;

  // Byte classes found by the front end.
  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_CONT,
    CLS_INVALID
  } byte_class_t;

  // Classified byte passed from front end to back end.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        end_of_string;
    byte_class_t cls;
  } cls_item_t;

  function automatic byte_class_t classify(input logic [7:0] b);
    byte_class_t c;
    priority casez (b)
      8'b0???????: c = CLS_ASCII;
      8'b10??????: c = CLS_CONT;
      8'b110?????: c = CLS_LEAD2;
      8'b1110????: c = CLS_LEAD3;
      8'b11110???: c = CLS_LEAD4;
      default:     c = CLS_INVALID;
    endcase
    return c;
  endfunction

  function automatic logic [20:0] min_for_length(input logic [2:0] n);
    logic [20:0] m;
    unique case (n)
      LEN_2:   m = CP_MIN_2;
      LEN_3:   m = CP_MIN_3;
      LEN_4:   m = CP_MIN_4;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/utf8_stream_decoder_unit.sv
// Top level of the UTF-8 stream decoder with validation.
// Unless stalled, the decoder takes one byte per clock and gives at most one
// result per byte: a result for every ASCII byte, for the last byte of a
// multi-byte sequence, and for every byte that ends a sequence in error (bad
// lead, truncated by the end-of-string mark, bad continuation, overlong,
// above 0x10FFFF, surrogate). Lead and middle bytes of a good sequence give
// no result. After any error the offending byte is dropped and decoding
// restarts idle; code_point is zero on every error. Sustained rate is one
// byte per clock while the consumer keeps popping. A pushed byte is held in
// the front-end queue, decoded combinationally in the back end, and its
// result (if any) is registered in the result queue that drives out_item.
// Both sides stall on their own: each side has a two-entry queue; in_full
// rises only after the result queue filled with the consumer not popping.
module utf8_stream_decoder_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input transactions
  input  logic                 in_push,
  output logic                 in_full,
  input  utf8d_pkg::in_item_t  in_item,
  // Result transactions
  output logic                 out_empty,
  input  logic                 out_pop,
  output utf8d_pkg::out_item_t out_item
);
  import utf8d_pkg::*;

  // Classified bytes between front and back end.
  logic      item_valid;
  logic      item_pop;
  cls_item_t item;

  // Front end: classify each byte and hold it until the decoder takes it.
  utf8d_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .item       (item)
  );

  // Back end: advance the sequence state and queue the results.
  utf8d_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .item       (item),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_item   (out_item)
  );

endmodule

>>> rtl/utf8d_front.sv
// Front end: accepts bytes, classifies them and queues them for the back end.
module utf8d_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  utf8d_pkg::in_item_t  in_item,
  output logic                 item_valid,
  input  logic                 item_pop,
  output utf8d_pkg::cls_item_t item
);
  import utf8d_pkg::*;

  cls_item_t  q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;
  cls_item_t  new_item;

  assign in_full    = (count_r == 2'd2);
  assign item_valid = (count_r != 2'd0);
  assign item       = q_r[rd_ptr_r];
  assign do_push    = in_push && !in_full;
  assign do_pop     = item_pop && item_valid;

  always_comb begin
    new_item.data_byte     = in_item.data_byte;
    new_item.end_of_string = in_item.end_of_string;
    new_item.cls           = classify(in_item.data_byte);
  end

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

>>> rtl/utf8d_back.sv
// Back end: runs the sequence decoder and queues results for the consumer.
module utf8d_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  output logic                 item_pop,
  input  utf8d_pkg::cls_item_t item,
  output logic                 out_empty,
  input  logic                 out_pop,
  output utf8d_pkg::out_item_t out_item
);
  import utf8d_pkg::*;

  // Decoder state.
  logic [2:0]  seq_total_r, seq_total_nxt;
  logic [2:0]  seq_seen_r, seq_seen_nxt;
  logic [20:0] acc_r, acc_nxt;

  // Result queue.
  out_item_t   rq_r [2];
  logic        rq_wr_r, rq_wr_nxt;
  logic        rq_rd_r, rq_rd_nxt;
  logic [1:0]  rq_cnt_r, rq_cnt_nxt;

  logic        res_full, take, emit, do_push, do_pop;
  out_item_t   res;
  logic [2:0]  seen;
  logic [20:0] v;

  assign res_full  = (rq_cnt_r == 2'd2);
  assign take      = item_valid && !res_full;
  assign item_pop  = take;
  assign do_push   = take && emit;
  assign out_empty = (rq_cnt_r == 2'd0);
  assign do_pop    = out_pop && !out_empty;
  assign out_item  = rq_r[rq_rd_r];

  assign seen = seq_seen_r + 3'd1;
  assign v    = {acc_r[14:0], item.data_byte[5:0]};

  always_comb begin
    emit          = 1'b0;
    res           = '0;
    seq_total_nxt = seq_total_r;
    seq_seen_nxt  = seq_seen_r;
    acc_nxt       = acc_r;
    if (seq_total_r == 3'd0) begin
      unique case (item.cls)
        CLS_ASCII: begin
          emit                = 1'b1;
          res.code_point      = {13'd0, item.data_byte};
          res.sequence_length = LEN_1;
          res.status          = ST_OK;
        end
        CLS_LEAD2, CLS_LEAD3, CLS_LEAD4: begin
          if (item.end_of_string) begin
            emit                = 1'b1;
            res.sequence_length = LEN_1;
            res.status          = ST_TRUNC;
          end else begin
            seq_seen_nxt = LEN_1;
            unique case (item.cls)
              CLS_LEAD2: begin
                seq_total_nxt = LEN_2;
                acc_nxt       = {16'd0, item.data_byte[4:0]};
              end
              CLS_LEAD3: begin
                seq_total_nxt = LEN_3;
                acc_nxt       = {17'd0, item.data_byte[3:0]};
              end
              default: begin
                seq_total_nxt = LEN_4;
                acc_nxt       = {18'd0, item.data_byte[2:0]};
              end
            endcase
          end
        end
        default: begin
          emit                = 1'b1;
          res.sequence_length = LEN_1;
          res.status          = ST_BAD_LEAD;
        end
      endcase
    end else begin
      priority if ((seen < seq_total_r) && item.end_of_string) begin
        emit                = 1'b1;
        res.sequence_length = seen;
        res.status          = ST_TRUNC;
      end else if (item.cls != CLS_CONT) begin
        emit                = 1'b1;
        res.sequence_length = seen;
        res.status          = ST_BAD_CONT;
      end else if (seen < seq_total_r) begin
        acc_nxt      = v;
        seq_seen_nxt = seen;
      end else begin
        emit                = 1'b1;
        res.sequence_length = seq_total_r;
        priority if (v < min_for_length(seq_total_r)) begin
          res.status = ST_OVERLONG;
        end else if (v > CP_MAX) begin
          res.status = ST_RANGE;
        end else if ((v >= CP_SURR_LO) && (v <= CP_SURR_HI)) begin
          res.status = ST_SURROGATE;
        end else begin
          res.status     = ST_OK;
          res.code_point = v;
        end
      end
    end
    // Any result returns the decoder to idle.
    if (emit) begin
      seq_total_nxt = 3'd0;
      seq_seen_nxt  = 3'd0;
      acc_nxt       = '0;
    end
  end

  always_comb begin
    rq_wr_nxt  = do_push ? ~rq_wr_r : rq_wr_r;
    rq_rd_nxt  = do_pop ? ~rq_rd_r : rq_rd_r;
    rq_cnt_nxt = rq_cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_total_r <= 3'd0;
      seq_seen_r  <= 3'd0;
      acc_r       <= '0;
      rq_wr_r     <= 1'b0;
      rq_rd_r     <= 1'b0;
      rq_cnt_r    <= 2'd0;
    end else begin
      if (take) begin
        seq_total_r <= seq_total_nxt;
        seq_seen_r  <= seq_seen_nxt;
        acc_r       <= acc_nxt;
      end
      rq_wr_r  <= rq_wr_nxt;
      rq_rd_r  <= rq_rd_nxt;
      rq_cnt_r <= rq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      rq_r[rq_wr_r] <= res;
    end
  end

endmodule
